@@ hw/rtl/glcw_pkg.sv @@
// ----------------------------------------------------------------------------
// glcw_pkg
// Shared widths, register map and controller/datapath signal groups for the
// grid line cell walker.
// ----------------------------------------------------------------------------
package glcw_pkg;

  localparam int IDX_W     = 12;  // linear cell index
  localparam int COL_W     = 6;   // column and row
  localparam int WIDTH_W   = 7;   // grid width register
  localparam int ERR_W     = 9;   // Bresenham error term
  localparam int DIV_CNT_W = 4;   // counts the IDX_W division steps
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [WIDTH_W-1:0] GRID_WIDTH_RESET = 7'd64;

  // Register index, taken from the word address bits of paddr.
  localparam logic [0:0] REG_GRID_WIDTH = 1'b0;

  typedef struct packed {
    logic div_start;
    logic walk_init;
    logic walk_step;
    logic emit_bad;
  } glcw_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic row_bad;
    logic out_free;
    logic walk_last;
  } glcw_status_t;

endpackage

@@ hw/rtl/glcw_req_if.sv @@
// ----------------------------------------------------------------------------
// glcw_req_if
// Request channel: start and end cell indices with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface glcw_req_if
  import glcw_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] start_index;
  logic [IDX_W-1:0] end_index;

  modport source (output valid, output start_index, output end_index, input ready);
  modport sink   (input valid, input start_index, input end_index, output ready);
endinterface

@@ hw/rtl/glcw_cell_if.sv @@
// ----------------------------------------------------------------------------
// glcw_cell_if
// Result channel: one visited cell per transfer with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface glcw_cell_if
  import glcw_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cell_index;
  logic [COL_W-1:0] cell_col;
  logic [COL_W-1:0] cell_row;
  logic             last;
  logic             bad_request;

  modport source (output valid, output cell_index, output cell_col, output cell_row,
                  output last, output bad_request, input ready);
  modport sink   (input valid, input cell_index, input cell_col, input cell_row,
                  input last, input bad_request, output ready);
endinterface

@@ hw/rtl/glcw_regs.sv @@
// ----------------------------------------------------------------------------
// glcw_regs
// APB register file holding the grid width, and the clamped width used by
// the datapath.
// ----------------------------------------------------------------------------
module glcw_regs
  import glcw_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output logic [WIDTH_W-1:0] width_o
);

  logic [WIDTH_W-1:0] grid_width_q;
  logic               hit;

  assign pready = 1'b1;
  assign hit    = (paddr[ADDR_W-1:ADDR_W-1] == REG_GRID_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q <= GRID_WIDTH_RESET;
    end else if (psel && penable && pwrite && hit) begin
      grid_width_q <= pwdata[WIDTH_W-1:0];
    end
  end

  assign prdata = hit ? {{(DATA_W-WIDTH_W){1'b0}}, grid_width_q} : '0;

  // A width of zero behaves as one; anything above the grid bound is clamped.
  always_comb begin
    if (grid_width_q == '0) begin
      width_o = WIDTH_W'(1);
    end else if (grid_width_q > WIDTH_W'(MAX_DIM)) begin
      width_o = WIDTH_W'(MAX_DIM);
    end else begin
      width_o = grid_width_q;
    end
  end

endmodule

@@ hw/rtl/glcw_div.sv @@
// ----------------------------------------------------------------------------
// glcw_div
// Two-lane restoring divider that splits the start and end indices into
// column (remainder) and row (quotient), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module glcw_div
  import glcw_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [IDX_W-1:0]   start_index_i,
  input  logic [IDX_W-1:0]   end_index_i,
  input  logic [WIDTH_W-1:0] width_i,
  output logic               busy_o,
  output logic               done_o,
  output logic               row_bad_o,
  output logic [COL_W-1:0]   start_col_o,
  output logic [COL_W-1:0]   start_row_o,
  output logic [COL_W-1:0]   end_col_o,
  output logic [COL_W-1:0]   end_row_o
);

  logic [WIDTH_W-1:0]   rem_q  [2];
  logic [IDX_W-1:0]     quo_q  [2];
  logic [WIDTH_W:0]     trial  [2];
  logic                 fits   [2];
  logic [WIDTH_W-1:0]   rem_nx [2];
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 run_q;
  logic                 done_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l]  = {rem_q[l], quo_q[l][IDX_W-1]};
      fits[l]   = (trial[l] >= {1'b0, width_i});
      rem_nx[l] = fits[l] ? WIDTH_W'(trial[l] - {1'b0, width_i}) : trial[l][WIDTH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(IDX_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q[0] <= '0;
      rem_q[1] <= '0;
      quo_q[0] <= start_index_i;
      quo_q[1] <= end_index_i;
    end else if (run_q) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= rem_nx[l];
        quo_q[l] <= {quo_q[l][IDX_W-2:0], fits[l]};
      end
    end
  end

  assign busy_o      = run_q;
  assign done_o      = done_q;
  assign row_bad_o   = (quo_q[0] >= IDX_W'(MAX_DIM)) || (quo_q[1] >= IDX_W'(MAX_DIM));
  assign start_col_o = rem_q[0][COL_W-1:0];
  assign start_row_o = quo_q[0][COL_W-1:0];
  assign end_col_o   = rem_q[1][COL_W-1:0];
  assign end_row_o   = quo_q[1][COL_W-1:0];

  a_rem_below_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q[0] < width_i) && (rem_q[1] < width_i))
    else $error("division remainder not below the grid width");

endmodule

@@ hw/rtl/glcw_walk.sv @@
// ----------------------------------------------------------------------------
// glcw_walk
// Bresenham walker and result register: steps the position one cell per
// transfer and forms each cell's linear index.
// ----------------------------------------------------------------------------
module glcw_walk
  import glcw_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  glcw_cmd_t          cmd_i,
  input  logic [WIDTH_W-1:0] width_i,
  input  logic [COL_W-1:0]   start_col_i,
  input  logic [COL_W-1:0]   start_row_i,
  input  logic [COL_W-1:0]   end_col_i,
  input  logic [COL_W-1:0]   end_row_i,
  output logic               out_free_o,
  output logic               walk_last_o,
  glcw_cell_if.source        cell_o
);

  localparam int NW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;

  logic [COL_W-1:0]        pos_col_q, pos_row_q, goal_col_q, goal_row_q;
  logic [COL_W:0]          span_x_q;
  logic signed [COL_W:0]   span_y_neg_q;
  logic signed [ERR_W-1:0] err_q;
  logic                    step_dir_x_q, step_dir_y_q;
  logic [NW-1:0]           n_q;

  logic signed [COL_W:0]   dcol, drow, span_y_neg_d;
  logic [COL_W:0]          span_x_d;
  logic signed [ERR_W-1:0] err_init, err_step;
  logic signed [ERR_W:0]   e2, xlim, ylim;
  logic                    move_x, move_y, done;
  logic [COL_W+WIDTH_W-1:0] prod;

  logic                    out_valid_q;
  logic [IDX_W-1:0]        out_index_q;
  logic [COL_W-1:0]        out_col_q, out_row_q;
  logic                    out_last_q, out_bad_q;

  always_comb begin
    dcol         = $signed({1'b0, end_col_i}) - $signed({1'b0, start_col_i});
    drow         = $signed({1'b0, end_row_i}) - $signed({1'b0, start_row_i});
    span_x_d     = dcol[COL_W] ? $unsigned(-dcol) : $unsigned(dcol);
    span_y_neg_d = drow[COL_W] ? drow : -drow;
    err_init     = $signed({2'b00, span_x_d}) + $signed({{2{span_y_neg_d[COL_W]}}, span_y_neg_d});

    e2       = {err_q, 1'b0};
    ylim     = {{3{span_y_neg_q[COL_W]}}, span_y_neg_q};
    xlim     = $signed({3'b000, span_x_q});
    move_x   = (e2 > ylim);
    move_y   = (e2 < xlim);
    err_step = err_q
             + (move_x ? $signed({{2{span_y_neg_q[COL_W]}}, span_y_neg_q}) : '0)
             + (move_y ? $signed({2'b00, span_x_q}) : '0);

    done = ((pos_col_q == goal_col_q) && (pos_row_q == goal_row_q)) ||
           (n_q == NW'(MAX_DIM - 1));
    prod = pos_row_q * width_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      pos_col_q    <= start_col_i;
      pos_row_q    <= start_row_i;
      goal_col_q   <= end_col_i;
      goal_row_q   <= end_row_i;
      span_x_q     <= span_x_d;
      span_y_neg_q <= span_y_neg_d;
      step_dir_x_q <= (end_col_i > start_col_i);
      step_dir_y_q <= (end_row_i > start_row_i);
      err_q        <= err_init;
      n_q          <= '0;
    end else if (cmd_i.walk_step && !done) begin
      if (move_x) begin
        pos_col_q <= step_dir_x_q ? pos_col_q + COL_W'(1) : pos_col_q - COL_W'(1);
      end
      if (move_y) begin
        pos_row_q <= step_dir_y_q ? pos_row_q + COL_W'(1) : pos_row_q - COL_W'(1);
      end
      err_q <= err_step;
      n_q   <= n_q + NW'(1);
    end
  end

  assign out_free_o = !out_valid_q || cell_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.walk_step || cmd_i.emit_bad) begin
      out_valid_q <= 1'b1;
    end else if (cell_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_step) begin
      out_index_q <= IDX_W'(prod) + IDX_W'(pos_col_q);
      out_col_q   <= pos_col_q;
      out_row_q   <= pos_row_q;
      out_last_q  <= done;
      out_bad_q   <= 1'b0;
    end else if (cmd_i.emit_bad) begin
      out_index_q <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_last_q  <= 1'b1;
      out_bad_q   <= 1'b1;
    end
  end

  assign walk_last_o        = done;
  assign cell_o.valid       = out_valid_q;
  assign cell_o.cell_index  = out_index_q;
  assign cell_o.cell_col    = out_col_q;
  assign cell_o.cell_row    = out_row_q;
  assign cell_o.last        = out_last_q;
  assign cell_o.bad_request = out_bad_q;

  a_bad_result_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_bad |=> out_valid_q && out_last_q && out_bad_q && (out_index_q == '0))
    else $error("rejected request did not produce a single flagged result");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.walk_step || cmd_i.emit_bad) |-> out_free_o)
    else $error("result register overwritten before its transfer");

endmodule

@@ hw/rtl/glcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// glcw_ctrl
// Request sequencer: accepts a request, waits for the index split, then
// either runs the walk or issues the rejection result.
// ----------------------------------------------------------------------------
module glcw_ctrl
  import glcw_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  output logic         req_ready_o,
  input  glcw_status_t status_i,
  output glcw_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_WALK,
    S_BAD
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o     = (state_q == S_IDLE);
  assign cmd_o.div_start = req_valid_i && req_ready_o;
  assign cmd_o.walk_init = (state_q == S_DIV) && status_i.div_done && !status_i.row_bad;
  assign cmd_o.walk_step = (state_q == S_WALK) && status_i.out_free;
  assign cmd_o.emit_bad  = (state_q == S_BAD) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_o.div_start) state_d = S_DIV;
      S_DIV: begin
        if (status_i.div_done) state_d = status_i.row_bad ? S_BAD : S_WALK;
      end
      S_WALK: if (cmd_o.walk_step && status_i.walk_last) state_d = S_IDLE;
      S_BAD:  if (cmd_o.emit_bad) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_accept_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> !status_i.div_busy)
    else $error("request accepted while the divider is running");

  a_last_cell_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.walk_step && status_i.walk_last) |=> req_ready_o)
    else $error("walker did not return to idle after the last cell");

endmodule

@@ hw/rtl/grid_line_cell_walker.sv @@
// ----------------------------------------------------------------------------
// grid_line_cell_walker
// Splits two linear grid indices into column and row, then walks the
// Bresenham line between them, one visited cell per result transfer.
// ----------------------------------------------------------------------------
// A request is accepted when the block is idle. Both indices are divided by
// the configured grid width in a shared two-lane restoring divider, one bit a
// cycle, and the controller then decides between the walk and the rejection;
// the walk produces one cell per cycle while the result side keeps taking
// transfers. A line has at most MAX_DIM cells.
// The next request is taken once the last cell is in the result register,
// while that cell still waits for its transfer. A request whose row reaches
// MAX_DIM yields one result with bad_request and last set. The grid width
// register (byte address 0) may only be written while no request is in flight.
// ----------------------------------------------------------------------------
module grid_line_cell_walker
  import glcw_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  glcw_req_if.sink          req_i,
  glcw_cell_if.source       cell_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  glcw_cmd_t          cmd;
  glcw_status_t       status;
  logic [WIDTH_W-1:0] width;
  logic [COL_W-1:0]   start_col, start_row, end_col, end_row;

  glcw_regs #(.MAX_DIM(MAX_DIM)) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .width_o (width)
  );

  glcw_div #(.MAX_DIM(MAX_DIM)) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (cmd.div_start),
    .start_index_i (req_i.start_index),
    .end_index_i   (req_i.end_index),
    .width_i       (width),
    .busy_o        (status.div_busy),
    .done_o        (status.div_done),
    .row_bad_o     (status.row_bad),
    .start_col_o   (start_col),
    .start_row_o   (start_row),
    .end_col_o     (end_col),
    .end_row_o     (end_row)
  );

  glcw_walk #(.MAX_DIM(MAX_DIM)) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .width_i     (width),
    .start_col_i (start_col),
    .start_row_i (start_row),
    .end_col_i   (end_col),
    .end_row_i   (end_row),
    .out_free_o  (status.out_free),
    .walk_last_o (status.walk_last),
    .cell_o      (cell_o)
  );

  glcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

endmodule
